// File: src/ssdf_pkg.sv
// shared types, constants and the segment table for the seven-segment framer
`default_nettype none

package ssdf_pkg;

   // display geometry
   localparam int DIGITS = 4;
   localparam int DIGIT_IDX_W = $clog2(DIGITS);
   localparam int STEP_W = 4;
   localparam int MAG_W = 14;

   // bus bytes
   localparam logic [7:0] MODE_AUTO = 8'h40;
   localparam logic [7:0] MODE_FIXED = 8'h44;
   localparam logic [7:0] ADDR_BASE = 8'hC0;
   localparam logic [7:0] CTRL_BASE = 8'h88;
   localparam logic [7:0] POINT_BIT = 8'h80;

   // symbol codes
   localparam logic [4:0] SYM_MINUS = 5'd16;
   localparam logic [4:0] SYM_BLANK = 5'd17;

   // number range
   localparam logic signed [14:0] VALUE_MAX = 15'sd9999;
   localparam logic signed [14:0] VALUE_MIN = -15'sd999;

   // command codes on the request beat
   localparam logic [1:0] CMD_NUMBER = 2'd0;
   localparam logic [1:0] CMD_SYMBOL = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // job kinds held in the queue
   localparam logic [1:0] KIND_NUMBER = 2'd0;
   localparam logic [1:0] KIND_SYMBOL = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // last sequencer step of each job kind
   localparam logic [STEP_W-1:0] NUM_LAST_STEP = 4'd6;
   localparam logic [STEP_W-1:0] SYM_LAST_STEP = 4'd3;
   localparam logic [STEP_W-1:0] CLR_LAST_STEP = STEP_W'(DIGITS * 4 - 1);

   // first digit step of a number frame
   localparam logic [STEP_W-1:0] NUM_DIGIT_STEP = 4'd2;

   // register indexes on the csr port
   localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
   localparam logic [1:0] REG_POINT_ENABLE = 2'd1;
   localparam logic [1:0] REG_BLANK_LEADING = 2'd2;

   // point position meaning none
   localparam logic [DIGIT_IDX_W-1:0] DP_NONE = 2'd3;

   typedef struct packed {
      logic [2:0] brightness;
      logic       point_enable;
      logic       blank_leading;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic                   negative;
      logic [MAG_W-1:0]       magnitude;
      logic [DIGIT_IDX_W-1:0] position;
      logic [4:0]             symbol;
      logic [DIGIT_IDX_W-1:0] dp_position;
   } job_type;

   // segment pattern of a symbol, unknown codes are blank
   function automatic logic [7:0] seg_of(input logic [4:0] sym);
      logic [7:0] seg;
      case (sym)
         5'd0: seg = 8'h3f;
         5'd1: seg = 8'h06;
         5'd2: seg = 8'h5b;
         5'd3: seg = 8'h4f;
         5'd4: seg = 8'h66;
         5'd5: seg = 8'h6d;
         5'd6: seg = 8'h7d;
         5'd7: seg = 8'h07;
         5'd8: seg = 8'h7f;
         5'd9: seg = 8'h6f;
         5'd10: seg = 8'h77;
         5'd11: seg = 8'h7c;
         5'd12: seg = 8'h39;
         5'd13: seg = 8'h5e;
         5'd14: seg = 8'h79;
         5'd15: seg = 8'h71;
         5'd16: seg = 8'h40;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   // k times the decimal weight of a digit place (place 0 is thousands)
   function automatic logic [MAG_W-1:0] place_mult(input logic [DIGIT_IDX_W-1:0] place,
                                                   input int k);
      logic [MAG_W-1:0] m;
      case (place)
         2'd0: m = MAG_W'(k * 1000);
         2'd1: m = MAG_W'(k * 100);
         2'd2: m = MAG_W'(k * 10);
         default: m = MAG_W'(k);
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// File: src/seven_segment_display_framer_unit.sv
// top level of the seven-segment display framer: csr registers and the front/queue/back chain
`default_nettype none

// Turns display commands into bus byte beats for a four-digit serial seven-segment
// controller, one beat per byte with start/stop markers in rsp_tuser and rsp_tlast on the
// final byte of each command. A number command gives 7 beats, a symbol command 4 and a
// clear command 16, at one beat per cycle from the back-end sequencer while rsp_tready does
// not stall the output; the next job is loaded from the two-entry queue only once the
// sequencer has built the final byte of the previous job and gone idle. Number commands
// outside -999..9999 and the unused command code are taken and give no beats. Request beats
// are accepted while the queue has room, also while the output beat waits. The csr registers
// are read while bytes are built, so write them only when the block is idle.
module seven_segment_display_framer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[1:0], value[16:2], position[18:17], symbol[23:19], dp_position[25:24]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // bus_byte[7:0]
   output logic [7:0]       rsp_tdata,
   // start_before[0], stop_after[1]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [2:0]  csr_wdata
);

   logic [2:0]        brightness_ff;
   logic              point_enable_ff;
   logic              blank_leading_ff;
   ssdf_pkg::cfg_type cfg;
   ssdf_pkg::job_type front_job;
   ssdf_pkg::job_type head_job;
   logic              push;
   logic              not_full;
   logic              not_empty;
   logic              pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= 3'd0;
         point_enable_ff <= 1'b1;
         blank_leading_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            ssdf_pkg::REG_BRIGHTNESS: brightness_ff <= csr_wdata;
            ssdf_pkg::REG_POINT_ENABLE: point_enable_ff <= csr_wdata[0];
            ssdf_pkg::REG_BLANK_LEADING: blank_leading_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.brightness = brightness_ff;
   assign cfg.point_enable = point_enable_ff;
   assign cfg.blank_leading = blank_leading_ff;

   ssdf_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_ready (not_full),
      .push        (push),
      .job         (front_job)
   );

   ssdf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (front_job),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   ssdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .job_valid  (not_empty),
      .job        (head_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: src/ssdf_front.sv
// front end: takes request beats, checks range, folds sign and classifies the job
`default_nettype none

module ssdf_front (
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [31:0]       req_tdata,
   input  wire logic              queue_ready,
   output logic                   push,
   output ssdf_pkg::job_type      job
);

   logic [1:0]         command;
   logic signed [14:0] value;
   logic signed [14:0] neg_value;
   logic               in_range;
   logic               keep;

   // field split
   assign command = req_tdata[1:0];
   assign value = $signed(req_tdata[16:2]);
   assign neg_value = -value;
   assign in_range = (value <= ssdf_pkg::VALUE_MAX) && (value >= ssdf_pkg::VALUE_MIN);

   // dropped commands are still taken but never reach the queue
   always_comb begin
      keep = 1'b0;
      job.kind = ssdf_pkg::KIND_NUMBER;
      case (command)
         ssdf_pkg::CMD_NUMBER: begin
            keep = in_range;
            job.kind = ssdf_pkg::KIND_NUMBER;
         end
         ssdf_pkg::CMD_SYMBOL: begin
            keep = 1'b1;
            job.kind = ssdf_pkg::KIND_SYMBOL;
         end
         ssdf_pkg::CMD_CLEAR: begin
            keep = 1'b1;
            job.kind = ssdf_pkg::KIND_CLEAR;
         end
         default: begin
            keep = 1'b0;
            job.kind = ssdf_pkg::KIND_CLEAR;
         end
      endcase
      job.negative = value[14];
      job.magnitude = value[14] ? neg_value[ssdf_pkg::MAG_W-1:0]
                                : value[ssdf_pkg::MAG_W-1:0];
      job.position = req_tdata[18:17];
      job.symbol = req_tdata[23:19];
      job.dp_position = req_tdata[25:24];
   end

   assign req_tready = queue_ready;
   assign push = req_tvalid && queue_ready && keep;

endmodule

`default_nettype wire

// File: src/ssdf_queue.sv
// two-entry job queue between the front end and the byte sequencer
`default_nettype none

module ssdf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ssdf_pkg::job_type push_job,
   output logic                   not_full,
   input  wire logic              pop,
   output logic                   not_empty,
   output ssdf_pkg::job_type      head_job
);

   ssdf_pkg::job_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              do_push;
   logic              do_pop;

   assign not_full = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push = push && not_full;
   assign do_pop = pop && not_empty;
   assign head_job = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: src/ssdf_back.sv
// back end: steps through a job's bus bytes, one decimal digit per digit beat
`default_nettype none

module ssdf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ssdf_pkg::cfg_type cfg,
   input  wire logic              job_valid,
   input  wire ssdf_pkg::job_type job,
   output logic                   job_pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int MW = ssdf_pkg::MAG_W;
   localparam int IW = ssdf_pkg::DIGIT_IDX_W;

   logic                          busy_ff;
   logic                          busy_in;
   ssdf_pkg::job_type             job_ff;
   logic [ssdf_pkg::STEP_W-1:0]   step_ff;
   logic [MW-1:0]                 rem_ff;
   logic [MW-1:0]                 rem_in;
   logic                          lead_ff;
   logic                          lead_in;
   logic                          valid_ff;
   logic [7:0]                    byte_ff;
   logic [7:0]                    byte_in;
   logic                          start_ff;
   logic                          start_in;
   logic                          stop_ff;
   logic                          stop_in;
   logic                          last_ff;
   logic                          last_in;
   logic                          adv;

   logic [IW-1:0]                 idx;
   logic                          is_minus;
   logic [3:0]                    digit;
   logic [MW-1:0]                 sub;
   logic [4:0]                    num_sym;
   logic [7:0]                    num_seg;
   logic [7:0]                    point;
   logic [7:0]                    ctrl;

   assign job_pop = !busy_ff && job_valid;
   assign adv = busy_ff && (!valid_ff || rsp_tready);
   assign point = cfg.point_enable ? ssdf_pkg::POINT_BIT : 8'h00;
   assign ctrl = ssdf_pkg::CTRL_BASE | {5'd0, cfg.brightness};

   // digit unit: compare against the nine multiples of the place weight
   always_comb begin
      idx = IW'(step_ff - ssdf_pkg::NUM_DIGIT_STEP);
      is_minus = job_ff.negative && (idx == '0);
      digit = 4'd0;
      sub = '0;
      for (int k = 1; k <= 9; k++) begin
         if (rem_ff >= ssdf_pkg::place_mult(idx, k)) begin
            digit = 4'(k);
            sub = ssdf_pkg::place_mult(idx, k);
         end
      end
      if (is_minus) begin
         num_sym = ssdf_pkg::SYM_MINUS;
      end else if (lead_ff && (digit == 4'd0) && (idx != IW'(ssdf_pkg::DIGITS - 1))) begin
         num_sym = ssdf_pkg::SYM_BLANK;
      end else begin
         num_sym = {1'b0, digit};
      end
      num_seg = ssdf_pkg::seg_of(num_sym) | point;
      if ((job_ff.dp_position != ssdf_pkg::DP_NONE) && (job_ff.dp_position == idx)) begin
         num_seg = num_seg | ssdf_pkg::POINT_BIT;
      end
   end

   // byte selection per job kind and step
   always_comb begin
      byte_in = ctrl;
      start_in = 1'b1;
      stop_in = 1'b1;
      last_in = 1'b0;
      rem_in = rem_ff;
      lead_in = lead_ff;
      case (job_ff.kind)
         ssdf_pkg::KIND_NUMBER: begin
            case (step_ff)
               4'd0: begin
                  byte_in = ssdf_pkg::MODE_AUTO;
               end
               4'd1: begin
                  byte_in = ssdf_pkg::ADDR_BASE;
                  stop_in = 1'b0;
               end
               4'd2, 4'd3, 4'd4, 4'd5: begin
                  byte_in = num_seg;
                  start_in = 1'b0;
                  stop_in = (idx == IW'(ssdf_pkg::DIGITS - 1));
                  if (!is_minus) begin
                     rem_in = rem_ff - sub;
                     lead_in = lead_ff && (digit == 4'd0);
                  end
               end
               default: begin
                  byte_in = ctrl;
                  last_in = 1'b1;
               end
            endcase
         end
         ssdf_pkg::KIND_SYMBOL: begin
            case (step_ff[1:0])
               2'd0: byte_in = ssdf_pkg::MODE_FIXED;
               2'd1: begin
                  byte_in = ssdf_pkg::ADDR_BASE | {6'd0, job_ff.position};
                  stop_in = 1'b0;
               end
               2'd2: begin
                  byte_in = ssdf_pkg::seg_of(job_ff.symbol) | point;
                  start_in = 1'b0;
               end
               default: begin
                  byte_in = ctrl;
                  last_in = 1'b1;
               end
            endcase
         end
         default: begin
            // clear: one blank symbol frame per digit
            case (step_ff[1:0])
               2'd0: byte_in = ssdf_pkg::MODE_FIXED;
               2'd1: begin
                  byte_in = ssdf_pkg::ADDR_BASE | {6'd0, step_ff[3:2]};
                  stop_in = 1'b0;
               end
               2'd2: begin
                  byte_in = ssdf_pkg::seg_of(ssdf_pkg::SYM_BLANK) | point;
                  start_in = 1'b0;
               end
               default: begin
                  byte_in = ctrl;
                  last_in = (step_ff == ssdf_pkg::CLR_LAST_STEP);
               end
            endcase
         end
      endcase
      busy_in = busy_ff;
      if (job_pop) begin
         busy_in = 1'b1;
      end else if (adv && last_in) begin
         busy_in = 1'b0;
      end
   end

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (adv) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // job, digit state and output beat
   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job;
         step_ff <= '0;
         rem_ff <= job.magnitude;
         lead_ff <= cfg.blank_leading;
      end else if (adv) begin
         step_ff <= step_ff + 4'd1;
         rem_ff <= rem_in;
         lead_ff <= lead_in;
      end
      if (adv) begin
         byte_ff <= byte_in;
         start_ff <= start_in;
         stop_ff <= stop_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = byte_ff;
   assign rsp_tuser = {stop_ff, start_ff};
   assign rsp_tlast = last_ff;

   // every command ends with a stop condition
   a_last_has_stop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> stop_ff)
      else $error("last beat without stop");

   // a number frame never runs past its control byte
   a_num_step_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (job_ff.kind == ssdf_pkg::KIND_NUMBER)) |-> (step_ff <= ssdf_pkg::NUM_LAST_STEP))
      else $error("number frame step overrun");

   // the remainder stays within four decimal digits
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (job_ff.kind == ssdf_pkg::KIND_NUMBER)) |-> (rem_ff <= MW'(9999)))
      else $error("digit remainder out of range");

   // a new job is only loaded into an idle sequencer
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (busy_ff && (step_ff == '0)))
      else $error("job load did not restart the sequencer");

endmodule

`default_nettype wire

// File: test/tb_seven_segment_display_framer_unit.sv
// testbench for the seven-segment display framer: command stream in, bus byte beats checked
`timescale 1ns / 100ps

module tb_seven_segment_display_framer_unit;

   // command code the block has no use for
   localparam logic [1:0] CMD_NONE = 2'd3;

   // bus bytes as the display controller expects them
   localparam logic [7:0] AUTO_MODE_BYTE = 8'h40;
   localparam logic [7:0] FIXED_MODE_BYTE = 8'h44;
   localparam logic [7:0] DIGIT_ADDR = 8'hC0;
   localparam logic [7:0] CONTROL_BASE = 8'h88;
   localparam logic [7:0] DOT_BIT = 8'h80;
   localparam logic [4:0] GLYPH_MINUS = 5'd16;
   localparam logic [4:0] GLYPH_BLANK = 5'd17;

   // segment patterns, glyph 0 in the low byte, glyph 17 (blank) on top
   localparam logic [18*8-1:0] GLYPHS = {
      8'h00, 8'h40, 8'h71, 8'h79, 8'h5e, 8'h39, 8'h7c, 8'h77, 8'h6f,
      8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
   };

   localparam int NUM_ROWS = 24;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 52;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       start_before;
      logic       stop_after;
      logic       last;
   } bus_beat_type;

   // one command; typed rows carry the segment byte of a symbol frame under reset settings
   typedef struct packed {
      logic [1:0]  cmd;
      logic [14:0] value;
      logic [1:0]  pos;
      logic [4:0]  sym;
      logic [1:0]  dp;
      logic        typed;
      logic [7:0]  seg;
   } step_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // command[1:0], value[16:2], position[18:17], symbol[23:19], dp_position[25:24]
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // bus_byte[7:0]
   logic [7:0]  rsp_tdata;
   // start_before[0], stop_after[1]
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [2:0]  csr_wdata;

   // mirror of the display settings
   logic [2:0] cfg_brightness;
   logic       cfg_point;
   logic       cfg_blank;

   bus_beat_type pending_bytes[$];
   step_row_type directed_rows [NUM_ROWS];
   int           fail_count = 0;
   bit           calm = 1'b0;

   seven_segment_display_framer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // give up long after the slowest correct run would have ended
   initial begin
      #15_000_000;
      $display("tb: failure");
      $finish;
   end

   // segment pattern of one glyph, codes past blank show nothing
   function automatic logic [7:0] glyph(input logic [4:0] sym);
      int k;
      k = sym;
      return (k < 18) ? GLYPHS[k*8 +: 8] : 8'h00;
   endfunction

   function automatic logic [7:0] dot_bits();
      return cfg_point ? DOT_BIT : 8'h00;
   endfunction

   function automatic logic [7:0] control_byte();
      return CONTROL_BASE + {5'd0, cfg_brightness};
   endfunction

   function automatic void push_beat(input logic [7:0] b, input logic st, input logic sp,
                                     input logic lst);
      bus_beat_type e;
      e.bus_byte = b;
      e.start_before = st;
      e.stop_after = sp;
      e.last = lst;
      pending_bytes.push_back(e);
   endfunction

   // fixed-address write of one digit
   function automatic void symbol_frame(input logic [1:0] pos, input logic [4:0] sym,
                                        input logic closes);
      push_beat(FIXED_MODE_BYTE, 1'b1, 1'b1, 1'b0);
      push_beat(DIGIT_ADDR | {6'd0, pos}, 1'b1, 1'b0, 1'b0);
      push_beat(glyph(sym) | dot_bits(), 1'b0, 1'b1, 1'b0);
      push_beat(control_byte(), 1'b1, 1'b1, closes);
   endfunction

   // queue up the bus bytes one command should produce
   function automatic void predict_frame(input step_row_type r);
      int         v;
      int         a;
      int         i;
      int         p;
      logic [4:0] d [4];
      logic [7:0] s;
      case (r.cmd)
         ssdf_pkg::CMD_NUMBER: begin
            v = $signed(r.value);
            if (v > 9999 || v < -999) return;
            if (v < 0) begin
               a = -v;
               d[0] = GLYPH_MINUS;
               d[1] = 5'(a / 100);
               d[2] = 5'((a / 10) % 10);
               d[3] = 5'(a % 10);
               // minus stays, zero hundreds then zero tens go dark
               if (cfg_blank && d[1] == 5'd0) begin
                  d[1] = GLYPH_BLANK;
                  if (d[2] == 5'd0) d[2] = GLYPH_BLANK;
               end
            end else begin
               a = v;
               d[0] = 5'(a / 1000);
               d[1] = 5'((a / 100) % 10);
               d[2] = 5'((a / 10) % 10);
               d[3] = 5'(a % 10);
               // leading zeros go dark, the ones digit always shows
               if (cfg_blank && d[0] == 5'd0) begin
                  d[0] = GLYPH_BLANK;
                  if (d[1] == 5'd0) begin
                     d[1] = GLYPH_BLANK;
                     if (d[2] == 5'd0) d[2] = GLYPH_BLANK;
                  end
               end
            end
            push_beat(AUTO_MODE_BYTE, 1'b1, 1'b1, 1'b0);
            push_beat(DIGIT_ADDR, 1'b1, 1'b0, 1'b0);
            for (i = 0; i < 4; i++) begin
               s = glyph(d[i]) | dot_bits();
               if (r.dp != ssdf_pkg::DP_NONE && i == int'(r.dp)) s = s | DOT_BIT;
               push_beat(s, 1'b0, i == 3, 1'b0);
            end
            push_beat(control_byte(), 1'b1, 1'b1, 1'b1);
         end
         ssdf_pkg::CMD_SYMBOL: symbol_frame(r.pos, r.sym, 1'b1);
         ssdf_pkg::CMD_CLEAR: begin
            for (p = 0; p < 4; p++) symbol_frame(2'(p), GLYPH_BLANK, p == 3);
         end
         default: return;
      endcase
   endfunction

   // random command, mostly well-formed numbers and symbols
   function automatic step_row_type random_row();
      step_row_type r;
      int           pick;
      r.typed = 1'b0;
      r.seg = 8'h00;
      r.value = 15'($urandom);
      r.pos = 2'($urandom);
      r.dp = 2'($urandom);
      r.sym = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 17));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.cmd = ssdf_pkg::CMD_NUMBER;
         case ($urandom_range(0, 6))
            0: ;
            1: r.value = 15'($urandom_range(0, 99));
            2: r.value = 15'(-int'($urandom_range(1, 999)));
            3: r.value = 15'(-int'($urandom_range(1, 99)));
            4, 5: r.value = 15'($urandom_range(0, 9999));
            default: begin
               case ($urandom_range(0, 4))
                  0: r.value = 15'(9999);
                  1: r.value = 15'(10000);
                  2: r.value = 15'(-999);
                  3: r.value = 15'(-1000);
                  default: r.value = 15'(0);
               endcase
            end
         endcase
      end else if (pick < 80) begin
         r.cmd = ssdf_pkg::CMD_SYMBOL;
      end else if (pick < 93) begin
         r.cmd = ssdf_pkg::CMD_CLEAR;
      end else begin
         r.cmd = CMD_NONE;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      fail_count++;
      if (fail_count <= 40)
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   // drive one command beat, log its expected bytes once taken, maybe pause afterwards
   task automatic send_item(input step_row_type r);
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, r.dp, r.sym, r.pos, r.value, r.cmd};
      do @(posedge clock); while (!req_tready);
      if (!r.typed) begin
         predict_frame(r);
      end else if (r.cmd == ssdf_pkg::CMD_SYMBOL) begin
         // reset settings: brightness 0, points on
         push_beat(8'h44, 1'b1, 1'b1, 1'b0);
         push_beat(8'hC0 | {6'd0, r.pos}, 1'b1, 1'b0, 1'b0);
         push_beat(r.seg, 1'b0, 1'b1, 1'b0);
         push_beat(8'h88, 1'b1, 1'b1, 1'b1);
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // stop sending and wait until every expected byte has come out
   task automatic drain_results(input int quiet_cycles);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
      repeat (quiet_cycles) @(posedge clock);
   endtask

   // write all three settings, one register per cycle
   task automatic program_regs(input logic [2:0] level, input logic dots, input logic blanking);
      csr_we <= 1'b1;
      csr_index <= ssdf_pkg::REG_BRIGHTNESS;
      csr_wdata <= level;
      @(posedge clock);
      csr_index <= ssdf_pkg::REG_POINT_ENABLE;
      csr_wdata <= {2'b00, dots};
      @(posedge clock);
      csr_index <= ssdf_pkg::REG_BLANK_LEADING;
      csr_wdata <= {2'b00, blanking};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_brightness = level;
      cfg_point = dots;
      cfg_blank = blanking;
   endtask

   // output side: ready stretches broken by stall bursts
   initial begin : byte_sink
      int hold;
      bit stalling;
      hold = 0;
      stalling = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            stalling = !calm && !stalling && ($urandom_range(0, 2) == 0);
            hold = stalling ? $urandom_range(1, 15) : $urandom_range(1, 30);
         end
         hold--;
         rsp_tready <= !stalling;
      end
   end

   // compare each output beat with the oldest expected byte
   always @(posedge clock) begin : byte_check
      bus_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("beat with nothing expected, byte", rsp_tdata, 8'h00);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.bus_byte)
               report_mismatch("bus_byte", rsp_tdata, want.bus_byte);
            if (rsp_tuser[0] !== want.start_before)
               report_mismatch("start_before", {7'd0, rsp_tuser[0]}, {7'd0, want.start_before});
            if (rsp_tuser[1] !== want.stop_after)
               report_mismatch("stop_after", {7'd0, rsp_tuser[1]}, {7'd0, want.stop_after});
            if (rsp_tlast !== want.last)
               report_mismatch("last", {7'd0, rsp_tlast}, {7'd0, want.last});
         end
      end
   end

   initial begin : stimulus
      int ph;
      int k;
      // cmd, value, pos, sym, dp, typed, seg
      directed_rows = '{
         {ssdf_pkg::CMD_SYMBOL, 15'd0, 2'd0, 5'd0, 2'd3, 1'b1, 8'hbf},
         {ssdf_pkg::CMD_SYMBOL, 15'd0, 2'd3, 5'd16, 2'd0, 1'b1, 8'hc0},
         {ssdf_pkg::CMD_SYMBOL, 15'h7fff, 2'd2, 5'd17, 2'd3, 1'b1, 8'h80},
         {ssdf_pkg::CMD_SYMBOL, 15'd0, 2'd1, 5'd31, 2'd3, 1'b1, 8'h80},
         {ssdf_pkg::CMD_SYMBOL, 15'd0, 2'd1, 5'd8, 2'd1, 1'b1, 8'hff},
         // out of range and the unused command give nothing
         {ssdf_pkg::CMD_NUMBER, 15'd10000, 2'd0, 5'd0, 2'd0, 1'b1, 8'h00},
         {ssdf_pkg::CMD_NUMBER, -15'sd1000, 2'd0, 5'd0, 2'd0, 1'b1, 8'h00},
         {ssdf_pkg::CMD_NUMBER, 15'h3fff, 2'd3, 5'd31, 2'd3, 1'b1, 8'h00},
         {ssdf_pkg::CMD_NUMBER, 15'h4000, 2'd0, 5'd0, 2'd1, 1'b1, 8'h00},
         {CMD_NONE, 15'd5, 2'd2, 5'd3, 2'd0, 1'b1, 8'h00},
         {ssdf_pkg::CMD_NUMBER, 15'd0, 2'd0, 5'd0, 2'd3, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, 15'd9999, 2'd0, 5'd0, 2'd0, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, -15'sd999, 2'd0, 5'd0, 2'd1, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, -15'sd1, 2'd0, 5'd0, 2'd2, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, -15'sd50, 2'd0, 5'd0, 2'd3, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, -15'sd105, 2'd0, 5'd0, 2'd3, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, 15'd7, 2'd0, 5'd0, 2'd3, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, 15'd70, 2'd0, 5'd0, 2'd2, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, 15'd700, 2'd0, 5'd0, 2'd3, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, 15'd1000, 2'd0, 5'd0, 2'd3, 1'b0, 8'h00},
         {ssdf_pkg::CMD_NUMBER, 15'd1234, 2'd0, 5'd0, 2'd1, 1'b0, 8'h00},
         {ssdf_pkg::CMD_SYMBOL, 15'd0, 2'd3, 5'd15, 2'd3, 1'b0, 8'h00},
         {ssdf_pkg::CMD_SYMBOL, 15'd0, 2'd0, 5'd10, 2'd3, 1'b0, 8'h00},
         {ssdf_pkg::CMD_CLEAR, 15'h7fff, 2'd3, 5'd5, 2'd2, 1'b0, 8'h00}
      };
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 32'd0;
      csr_we <= 1'b0;
      csr_index <= ssdf_pkg::REG_BRIGHTNESS;
      csr_wdata <= 3'd0;
      cfg_brightness = 3'd0;
      cfg_point = 1'b1;
      cfg_blank = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed commands under reset settings
      for (k = 0; k < NUM_ROWS; k++) send_item(directed_rows[k]);

      // random phases, settings changed only while idle
      for (ph = 0; ph < PHASES; ph++) begin
         drain_results(SETTLE_CYCLES);
         case (ph)
            0: program_regs(3'd7, 1'b0, 1'b1);
            1: program_regs(3'd0, 1'b1, 1'b0);
            2: program_regs(3'd7, 1'b1, 1'b0);
            3: program_regs(3'd0, 1'b0, 1'b0);
            default: program_regs(3'($urandom), 1'($urandom), 1'($urandom));
         endcase
         if (ph == PHASES - 1) calm = 1'b1;
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            // hold off mid-phase until the output side has caught up
            if (ph == 2 && k == ITEMS_PER_PHASE / 2) drain_results(0);
            send_item(random_row());
         end
      end

      drain_results(SETTLE_CYCLES);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
